// ===== src/ptd_pkg.sv =====
// Shared types and constants for the periodic task dispatcher.
// No dependencies; imported by ptd_div, periodic_task_dispatcher and the testbench.
`default_nettype none
package ptd_pkg;

    localparam int MAX_TASKS_DEF  = 16;
    localparam int DATA_W         = 32;
    localparam int SHARE_W        = 10;
    localparam int SCALED_W       = DATA_W + SHARE_W;
    localparam logic [SHARE_W-1:0] PERMILLE_MAX = SHARE_W'(1000);
    localparam logic [DATA_W-1:0]  WINDOW_RESET = 32'd1000000;
    localparam int S_TDATA_W      = 112;
    localparam int M_TDATA_W      = 192;
    localparam logic REG_CPU_WINDOW = 1'b0;

    typedef enum logic [2:0] {
        ACT_REGISTER = 3'd0,
        ACT_SET_EN   = 3'd1,
        ACT_POLL     = 3'd2,
        ACT_DONE     = 3'd3,
        ACT_TICK     = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_SKIP     = 3'd2,
        ST_RUN      = 3'd3,
        ST_TICK     = 3'd4,
        ST_WINDOW   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_BDIV,
        S_CRD,
        S_CSTART,
        S_CDIV,
        S_PUT
    } state_t;

    typedef struct packed {
        logic [31:0] elapsed_us;
        logic        gate_open;
        logic        enable;
        logic        gate_bypass;
        logic [31:0] period_len;
        logic [31:0] now_us;
        logic [3:0]  task_index;
        logic [2:0]  action;
    } in_item_t;

    typedef struct packed {
        logic [31:0] peak_tick_us;
        logic [31:0] tick_count;
        logic [9:0]  busy_load;
        logic [9:0]  task_load;
        logic [31:0] max_elapsed_us;
        logic [31:0] last_elapsed_us;
        logic [31:0] invocations;
        logic [3:0]  task_id;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] next_due;
        logic        gate_bypass;
        logic        en;
    } cfg_row_t;

    typedef struct packed {
        logic [31:0] runs;
        logic [31:0] last_time;
        logic [31:0] max_time;
        logic [31:0] win_time;
        logic [9:0]  share;
    } stat_row_t;

    typedef struct packed {
        logic        start;
        logic [31:0] part;
        logic [31:0] span;
    } div_req_t;

endpackage
`default_nettype wire

// ===== src/ptd_div.sv =====
// Iterative permille divider: min(part * 1000 / span, 1000), one quotient bit per cycle.
// Depends on ptd_pkg.
`default_nettype none
module ptd_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptd_pkg::div_req_t req,
    output logic                   busy,
    output logic                   done,
    output logic [9:0]             share
);
    import ptd_pkg::*;

    localparam int CNT_W = $clog2(SCALED_W + 1);

    logic [SCALED_W-1:0] sh_reg, sh_next;
    logic [DATA_W:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]   dsr_reg, dsr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [SCALED_W-1:0] scaled;
    logic [DATA_W:0]     rem_sh;
    logic                ge;

    // part * 1000 = part * 1024 - part * 16 - part * 8
    assign scaled = (SCALED_W'(req.part) << 10) - (SCALED_W'(req.part) << 4)
                  - (SCALED_W'(req.part) << 3);
    assign rem_sh = {rem_reg[DATA_W-1:0], sh_reg[SCALED_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            sh_next  = scaled;
            rem_next = '0;
            dsr_next = req.span;
            cnt_next = CNT_W'(SCALED_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            sh_next   = {sh_reg[SCALED_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy  = (cnt_reg != '0);
    assign done  = done_reg;
    assign share = ((sh_reg[SCALED_W-1:SHARE_W] != '0) || (sh_reg[SHARE_W-1:0] > PERMILLE_MAX))
                 ? PERMILLE_MAX : sh_reg[SHARE_W-1:0];

endmodule
`default_nettype wire

// ===== src/periodic_task_dispatcher.sv =====
// Periodic task dispatcher: task tables, sequencer, output register, APB register.
// Depends on ptd_pkg and ptd_div.
// One word in flight: s_axis_tready is high only in S_IDLE; each word passes S_DECODE then S_PUT,
// with S_EXEC, the table update, between them for set enable, poll and done on a valid index.
// A window close divides the busy share (S_BDIV), then per task reads, starts and divides.
// Reset (rst_n, async low) clears count, statistics valid bits and tick state.
`default_nettype none
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // action, task_index, now_us, period_len, gate_bypass, enable, gate_open, elapsed_us
    input  wire logic [ptd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // status, task_id, invocations, last_elapsed_us, max_elapsed_us, task_load,
    // busy_load, tick_count, peak_tick_us
    output logic [ptd_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import ptd_pkg::*;

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int RW = $bits(result_t);

    state_t    state_reg, state_next;
    in_item_t  in_reg, in_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic [31:0] window_reg;
    logic [31:0] ticks_reg, ticks_next;
    logic [31:0] longest_reg, longest_next;
    logic [31:0] busy_reg, busy_next;
    logic [31:0] wstart_reg, wstart_next;
    logic [31:0] span_reg, span_next;
    logic [9:0]  bshare_reg, bshare_next;
    result_t   res_reg, res_next;
    logic      res_last_reg, res_last_next;
    result_t   out_reg;
    logic      out_last_reg, out_valid_reg;

    cfg_row_t  cfg_mem [MAX_TASKS];
    stat_row_t stat_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] stat_vld_reg;
    cfg_row_t  cfg_rd_reg, cfg_wdata;
    stat_row_t stat_rd_reg, stat_wdata, stat_cur;
    logic      vld_rd_reg;
    logic      cfg_we, stat_we;
    logic [AW-1:0] cfg_waddr, stat_waddr, rd_addr;

    logic [6:0]  idx_ext;
    logic        bad_idx, table_full, s_accept, out_free, load_out;
    logic [31:0] span_c, diff_c;
    logic        close_c, run_c;
    div_req_t    div_req;
    logic        div_busy, div_done;
    logic [9:0]  div_share;

    ptd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .done  (div_done),
        .share (div_share)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign load_out      = (state_reg == S_PUT) && out_free;

    assign idx_ext    = 7'(in_reg.task_index);
    assign bad_idx    = (idx_ext >= 7'(count_reg)) || (idx_ext >= 7'(MAX_TASKS));
    assign table_full = (count_reg == CW'(MAX_TASKS));
    assign span_c     = in_reg.now_us - wstart_reg;
    assign close_c    = (wstart_reg != '0) && (span_c != '0) && (span_c >= window_reg);
    assign diff_c     = in_reg.now_us - cfg_rd_reg.next_due;
    assign run_c      = cfg_rd_reg.en && (cfg_rd_reg.gate_bypass || in_reg.gate_open)
                      && ((cfg_rd_reg.period == '0) || !diff_c[31]);
    assign stat_cur   = vld_rd_reg ? stat_rd_reg : '0;
    assign rd_addr    = (state_reg == S_CRD || state_reg == S_CSTART || state_reg == S_CDIV)
                      ? slot_reg[AW-1:0] : idx_ext[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_accept)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                case (in_reg.action)
                    ACT_SET_EN, ACT_POLL, ACT_DONE:
                        state_next = bad_idx ? S_PUT : S_EXEC;
                    ACT_TICK:
                        state_next = close_c ? S_BDIV : S_PUT;
                    default:
                        state_next = S_PUT;
                endcase
            end
            S_EXEC:
                state_next = S_PUT;
            S_BDIV:
                if (div_done)
                    state_next = (count_reg == '0) ? S_PUT : S_CRD;
            S_CRD:
                state_next = S_CSTART;
            S_CSTART:
                state_next = S_CDIV;
            S_CDIV:
                if (div_done)
                    state_next = S_PUT;
            S_PUT:
                if (out_free)
                    state_next = res_last_reg ? S_IDLE : S_CRD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb
    begin
        in_next       = in_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        ticks_next    = ticks_reg;
        longest_next  = longest_reg;
        busy_next     = busy_reg;
        wstart_next   = wstart_reg;
        span_next     = span_reg;
        bshare_next   = bshare_reg;
        res_next      = res_reg;
        res_last_next = res_last_reg;
        cfg_we        = 1'b0;
        cfg_waddr     = idx_ext[AW-1:0];
        cfg_wdata     = cfg_rd_reg;
        stat_we       = 1'b0;
        stat_waddr    = idx_ext[AW-1:0];
        stat_wdata    = stat_cur;
        div_req       = '{start: 1'b0, part: stat_cur.win_time, span: span_reg};
        case (state_reg)
            S_IDLE:
                if (s_accept)
                    in_next = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
            S_DECODE:
            begin
                res_next      = '0;
                res_last_next = 1'b1;
                res_next.status  = ST_REJECTED;
                res_next.task_id = in_reg.task_index;
                case (in_reg.action)
                    ACT_REGISTER:
                    begin
                        res_next.task_id = '0;
                        if (!table_full)
                        begin
                            cfg_we    = 1'b1;
                            cfg_waddr = count_reg[AW-1:0];
                            cfg_wdata = '{period: in_reg.period_len, next_due: in_reg.now_us,
                                          gate_bypass: in_reg.gate_bypass, en: 1'b1};
                            res_next.status  = ST_ACCEPTED;
                            res_next.task_id = 4'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_TICK:
                    begin
                        ticks_next   = ticks_reg + 32'd1;
                        longest_next = (in_reg.elapsed_us > longest_reg)
                                     ? in_reg.elapsed_us : longest_reg;
                        busy_next    = busy_reg + in_reg.elapsed_us;
                        span_next    = span_c;
                        if (wstart_reg == '0)
                            wstart_next = in_reg.now_us;
                        if (close_c)
                            div_req = '{start: 1'b1, part: busy_next, span: span_c};
                        res_next.status       = ST_TICK;
                        res_next.task_id      = '0;
                        res_next.busy_load    = bshare_reg;
                        res_next.tick_count   = ticks_next;
                        res_next.peak_tick_us = longest_next;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_EXEC:
            begin
                case (in_reg.action)
                    ACT_SET_EN:
                    begin
                        cfg_we          = 1'b1;
                        cfg_wdata.en    = in_reg.enable;
                        res_next.status = ST_ACCEPTED;
                    end
                    ACT_POLL:
                    begin
                        if (run_c && (cfg_rd_reg.period != '0))
                        begin
                            cfg_we             = 1'b1;
                            cfg_wdata.next_due = in_reg.now_us + cfg_rd_reg.period;
                        end
                        res_next.status = run_c ? ST_RUN : ST_SKIP;
                    end
                    default:
                    begin
                        stat_we              = 1'b1;
                        stat_wdata.runs      = stat_cur.runs + 32'd1;
                        stat_wdata.last_time = in_reg.elapsed_us;
                        stat_wdata.win_time  = stat_cur.win_time + in_reg.elapsed_us;
                        if (in_reg.elapsed_us > stat_cur.max_time)
                            stat_wdata.max_time = in_reg.elapsed_us;
                        res_next.status          = ST_ACCEPTED;
                        res_next.invocations     = stat_wdata.runs;
                        res_next.last_elapsed_us = stat_wdata.last_time;
                        res_next.max_elapsed_us  = stat_wdata.max_time;
                        res_next.task_load       = stat_cur.share;
                    end
                endcase
            end
            S_BDIV:
                if (div_done)
                begin
                    bshare_next = div_share;
                    busy_next   = '0;
                    wstart_next = in_reg.now_us;
                    slot_next   = '0;
                    res_next.busy_load = div_share;
                end
            S_CSTART:
                div_req.start = 1'b1;
            S_CDIV:
                if (div_done)
                begin
                    stat_we             = 1'b1;
                    stat_waddr          = slot_reg[AW-1:0];
                    stat_wdata.win_time = '0;
                    stat_wdata.share    = div_share;
                    res_next              = '0;
                    res_next.status       = ST_WINDOW;
                    res_next.task_id      = 4'(slot_reg);
                    res_next.task_load    = div_share;
                    res_next.busy_load    = bshare_reg;
                    res_next.tick_count   = ticks_reg;
                    res_next.peak_tick_us = longest_reg;
                    res_last_next = (CW'(slot_reg + CW'(1)) == count_reg);
                end
            S_PUT:
                if (out_free && !res_last_reg)
                    slot_next = slot_reg + CW'(1);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ticks_reg     <= '0;
            longest_reg   <= '0;
            busy_reg      <= '0;
            wstart_reg    <= '0;
            bshare_reg    <= '0;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
            stat_vld_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ticks_reg   <= ticks_next;
            longest_reg <= longest_next;
            busy_reg    <= busy_next;
            wstart_reg  <= wstart_next;
            bshare_reg  <= bshare_next;
            if (psel && penable && pwrite && (paddr[2] == REG_CPU_WINDOW))
                window_reg <= pwdata;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (stat_we)
                stat_vld_reg[stat_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        slot_reg     <= slot_next;
        span_reg     <= span_next;
        res_reg      <= res_next;
        res_last_reg <= res_last_next;
        if (load_out)
        begin
            out_reg      <= res_reg;
            out_last_reg <= res_last_reg;
        end
    end

    // task tables
    always_ff @(posedge clk)
    begin
        if (cfg_we)
            cfg_mem[cfg_waddr] <= cfg_wdata;
        if (stat_we)
            stat_mem[stat_waddr] <= stat_wdata;
        cfg_rd_reg  <= cfg_mem[rd_addr];
        stat_rd_reg <= stat_mem[rd_addr];
        vld_rd_reg  <= stat_vld_reg[rd_addr];
    end

    assign prdata        = (paddr[2] == REG_CPU_WINDOW) ? window_reg : '0;
    assign pready        = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - RW)'(0), out_reg};
    assign m_axis_tlast  = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("task count beyond table depth");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_BDIV || state_reg == S_CDIV))
        else $error("divider running outside a window close");

    a_window_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRD) |-> (slot_reg < count_reg))
        else $error("window report walks past the registered tasks");

    a_put_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT && !out_free) |=> (state_reg == S_PUT))
        else $error("result dropped while output register busy");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for periodic_task_dispatcher: random and directed stream words
// checked against a behavioral predictor kept in a scoreboard class.
// Depends on ptd_pkg and the dispatcher RTL.
`timescale 1ns / 100ps
`default_nettype none

import ptd_pkg::*;

class dispatch_scoreboard;
    logic [31:0] window_len;
    int unsigned n_tasks;
    logic [31:0] period_q [16];
    logic [31:0] due_q [16];
    bit          en_q [16];
    bit          bypass_q [16];
    logic [31:0] runs_q [16];
    logic [31:0] last_q [16];
    logic [31:0] max_q [16];
    logic [31:0] win_q [16];
    logic [9:0]  share_q [16];
    logic [31:0] ticks;
    logic [31:0] longest;
    logic [31:0] busy;
    logic [31:0] win_start;
    logic [9:0]  busy_share;
    result_t     pending [$];
    bit          last_pending [$];
    int          errors;

    function new();
        window_len = WINDOW_RESET;
        n_tasks = 0;
        ticks = 0;
        longest = 0;
        busy = 0;
        win_start = 0;
        busy_share = 0;
        errors = 0;
        for (int i = 0; i < 16; i++)
        begin
            period_q[i] = 0; due_q[i] = 0; en_q[i] = 0; bypass_q[i] = 0;
            runs_q[i] = 0; last_q[i] = 0; max_q[i] = 0; win_q[i] = 0; share_q[i] = 0;
        end
    endfunction

    function logic [9:0] share_of(logic [31:0] part, logic [31:0] span);
        logic [63:0] v;
        v = (64'(part) * 64'd1000) / 64'(span);
        return (v > 64'd1000) ? 10'd1000 : v[9:0];
    endfunction

    function void push(result_t r, bit l);
        pending.push_back(r);
        last_pending.push_back(l);
    endfunction

    function void note_item(in_item_t it);
        result_t r;
        logic [31:0] span;
        bit run;
        bit closed;
        int i;
        r = '0;
        case (it.action)
            ACT_REGISTER:
            begin
                if (n_tasks >= 16)
                    r.status = ST_REJECTED;
                else
                begin
                    i = n_tasks++;
                    period_q[i] = it.period_len;
                    due_q[i] = it.now_us;
                    en_q[i] = 1;
                    bypass_q[i] = it.gate_bypass;
                    r.status = ST_ACCEPTED;
                    r.task_id = 4'(i);
                end
                push(r, 1);
            end
            ACT_SET_EN, ACT_POLL, ACT_DONE:
            begin
                i = it.task_index;
                r.task_id = it.task_index;
                if (i >= n_tasks)
                    r.status = ST_REJECTED;
                else if (it.action == ACT_SET_EN)
                begin
                    en_q[i] = it.enable;
                    r.status = ST_ACCEPTED;
                end
                else if (it.action == ACT_POLL)
                begin
                    run = 1;
                    if (!en_q[i])
                        run = 0;
                    else if (!bypass_q[i] && !it.gate_open)
                        run = 0;
                    else if (period_q[i] != 0 && ((it.now_us - due_q[i]) >> 31))
                        run = 0;
                    if (run && period_q[i] != 0)
                        due_q[i] = it.now_us + period_q[i];
                    r.status = run ? ST_RUN : ST_SKIP;
                end
                else
                begin
                    runs_q[i] += 1;
                    last_q[i] = it.elapsed_us;
                    win_q[i] += it.elapsed_us;
                    if (it.elapsed_us > max_q[i])
                        max_q[i] = it.elapsed_us;
                    r.status = ST_ACCEPTED;
                    r.invocations = runs_q[i];
                    r.last_elapsed_us = last_q[i];
                    r.max_elapsed_us = max_q[i];
                    r.task_load = share_q[i];
                end
                push(r, 1);
            end
            ACT_TICK:
            begin
                closed = 0;
                ticks += 1;
                if (it.elapsed_us > longest)
                    longest = it.elapsed_us;
                busy += it.elapsed_us;
                if (win_start == 0)
                    win_start = it.now_us;
                else
                begin
                    span = it.now_us - win_start;
                    if (span != 0 && span >= window_len)
                    begin
                        for (i = 0; i < n_tasks; i++)
                        begin
                            share_q[i] = share_of(win_q[i], span);
                            win_q[i] = 0;
                        end
                        busy_share = share_of(busy, span);
                        busy = 0;
                        win_start = it.now_us;
                        closed = 1;
                    end
                end
                r.busy_load = busy_share;
                r.tick_count = ticks;
                r.peak_tick_us = longest;
                if (closed && n_tasks > 0)
                begin
                    for (i = 0; i < n_tasks; i++)
                    begin
                        r.status = ST_WINDOW;
                        r.task_id = 4'(i);
                        r.task_load = share_q[i];
                        push(r, i == n_tasks - 1);
                    end
                end
                else
                begin
                    r.status = ST_TICK;
                    push(r, 1);
                end
            end
            default:
            begin
                r.status = ST_REJECTED;
                r.task_id = it.task_index;
                push(r, 1);
            end
        endcase
    endfunction

    function void check_result(result_t got, bit got_last);
        result_t w;
        bit wl;
        if (pending.size() == 0)
        begin
            $error("unexpected result word %h", got);
            errors++;
            return;
        end
        w = pending.pop_front();
        wl = last_pending.pop_front();
        if (got.status !== w.status)
        begin
            $error("status exp %0d got %0d", w.status, got.status); errors++;
        end
        if (got.task_id !== w.task_id)
        begin
            $error("task_id exp %0d got %0d", w.task_id, got.task_id); errors++;
        end
        if (got.invocations !== w.invocations)
        begin
            $error("invocations exp %0d got %0d", w.invocations, got.invocations); errors++;
        end
        if (got.last_elapsed_us !== w.last_elapsed_us)
        begin
            $error("last_elapsed_us exp %0d got %0d", w.last_elapsed_us,
                got.last_elapsed_us);
            errors++;
        end
        if (got.max_elapsed_us !== w.max_elapsed_us)
        begin
            $error("max_elapsed_us exp %0d got %0d", w.max_elapsed_us,
                got.max_elapsed_us);
            errors++;
        end
        if (got.task_load !== w.task_load)
        begin
            $error("task_load exp %0d got %0d", w.task_load, got.task_load);
            errors++;
        end
        if (got.busy_load !== w.busy_load)
        begin
            $error("busy_load exp %0d got %0d", w.busy_load, got.busy_load);
            errors++;
        end
        if (got.tick_count !== w.tick_count)
        begin
            $error("tick_count exp %0d got %0d", w.tick_count, got.tick_count); errors++;
        end
        if (got.peak_tick_us !== w.peak_tick_us)
        begin
            $error("peak_tick_us exp %0d got %0d", w.peak_tick_us, got.peak_tick_us);
            errors++;
        end
        if (got_last !== wl)
        begin
            $error("last exp %0d got %0d", wl, got_last); errors++;
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    dispatch_scoreboard sb;
    int unsigned cycles = 0;
    logic [31:0] clock_us = 1;
    bit sink_running = 1;

    periodic_task_dispatcher dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Sink: random stall before each word, check on acceptance.
    initial
    begin
        int gap;
        sb = new();
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1;
            do @(posedge clk); while (!m_axis_tvalid);
            sb.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]), m_axis_tlast);
        end
    end

    task automatic send_word(in_item_t it);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= S_TDATA_W'(it);
        s_axis_tvalid <= 1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_window(logic [31:0] v);
        drain();
        psel <= 1; pwrite <= 1; paddr <= {REG_CPU_WINDOW, 2'b00}; pwdata <= v; penable <= 0;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.window_len = v;
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    function automatic in_item_t rand_item();
        in_item_t it;
        it.action = 3'($urandom_range(0, 4));
        if ($urandom_range(0, 29) == 0)
            it.action = 3'($urandom_range(5, 7));
        it.task_index = (sb.n_tasks > 0 && $urandom_range(0, 7) != 0) ?
            4'($urandom_range(0, sb.n_tasks - 1)) : 4'($urandom_range(0, 15));
        it.now_us = ($urandom_range(0, 9) == 0) ? $urandom : clock_us;
        it.period_len = $urandom_range(0, 3) == 0 ? $urandom :
            ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60));
        it.gate_bypass = 1'($urandom);
        it.enable = ($urandom_range(0, 3) != 0);
        it.gate_open = 1'($urandom);
        it.elapsed_us = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40);
        return it;
    endfunction

    function automatic in_item_t mk(action_t a, logic [3:0] idx, logic [31:0] now,
        logic [31:0] per, bit al, bit en, bit g, logic [31:0] el);
        in_item_t it;
        it = '{elapsed_us: el, gate_open: g, enable: en, gate_bypass: al, period_len: per,
            now_us: now, task_index: idx, action: a};
        return it;
    endfunction

    initial
    begin
        in_item_t it;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: unregistered slots, registers, gating, wrap, full table.
        send_word(mk(ACT_POLL, 4'd15, 32'd5, 0, 0, 0, 1, 0));
        send_word(mk(ACT_TICK, 4'd0, 32'd0, 0, 0, 0, 0, 32'd7));
        send_word(mk(ACT_REGISTER, 4'd0, 32'd100, 32'd0, 1, 0, 0, 0));
        send_word(mk(ACT_REGISTER, 4'd0, 32'hFFFF_FFF0, 32'd50, 0, 0, 0, 0));
        send_word(mk(ACT_REGISTER, 4'd0, 32'd10, 32'hFFFF_FFFF, 1, 0, 0, 0));
        send_word(mk(ACT_POLL, 4'd0, 32'd1, 0, 0, 0, 0, 0));
        send_word(mk(ACT_POLL, 4'd1, 32'd20, 0, 0, 0, 0, 0));
        send_word(mk(ACT_POLL, 4'd1, 32'd20, 0, 0, 0, 1, 0));
        send_word(mk(ACT_POLL, 4'd1, 32'd21, 0, 0, 0, 1, 0));
        send_word(mk(ACT_SET_EN, 4'd2, 0, 0, 0, 0, 0, 0));
        send_word(mk(ACT_POLL, 4'd2, 32'd10, 0, 0, 0, 1, 0));
        send_word(mk(ACT_SET_EN, 4'd2, 0, 0, 0, 1, 0, 0));
        send_word(mk(ACT_DONE, 4'd0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_word(mk(ACT_DONE, 4'd0, 0, 0, 0, 0, 0, 32'd3));
        send_word(mk(action_t'(3'd7), 4'd9, 0, 0, 0, 0, 0, 0));
        send_word(mk(ACT_TICK, 4'd0, 32'd1000, 0, 0, 0, 0, 32'd100));
        send_word(mk(ACT_TICK, 4'd0, 32'd1000, 0, 0, 0, 0, 32'd0));
        set_window(32'd1);
        send_word(mk(ACT_TICK, 4'd0, 32'd1001, 0, 0, 0, 0, 32'hFFFF_FFFF));
        repeat (14)
            send_word(mk(ACT_REGISTER, 4'd0, 32'd5, 32'd3, 0, 0, 0, 0));
        set_window(32'hFFFF_FFFF);
        send_word(mk(ACT_TICK, 4'd0, 32'd1000, 0, 0, 0, 0, 32'd1));

        set_window(32'd200);
        for (int n = 0; n < 370; n++)
        begin
            if (n == 120)
                set_window(32'd1000);
            if (n == 250)
                set_window(32'd37);
            clock_us = clock_us + $urandom_range(0, 30);
            it = rand_item();
            if ($urandom_range(0, 60) == 0)
                drain();
            send_word(it);
        end
        drain();
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
src/ptd_pkg.sv
src/ptd_div.sv
src/periodic_task_dispatcher.sv
test/tb.sv
